FILE: design/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types, codes and constants shared by the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  localparam int unsigned LenWidthDefault = 64;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_EMPTY   = 3'd1,
    KIND_CLOSE   = 3'd2,
    KIND_PING    = 3'd3,
    KIND_PONG    = 3'd4
  } kind_e;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [2:0] EXT_CNT16 = 3'd1;
  localparam logic [2:0] EXT_CNT64 = 3'd7;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic       is_binary;
    logic       last;
  } res_t;

endpackage

FILE: design/wsfd_parse.sv
// ----------------------------------------------------------------------------
// wsfd_parse
// Frame state and per-byte decode: header, extended length, mask key, payload.
// ----------------------------------------------------------------------------
module wsfd_parse #(
  parameter int unsigned LEN_WIDTH = wsfd_pkg::LenWidthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_i,
  input  logic [7:0]     rx_byte_i,
  output logic           res_vld_o,
  output wsfd_pkg::res_t res_o
);

  wsfd_pkg::phase_e     phase_q, phase_d;
  logic [2:0]           ext_q, ext_d;
  logic [3:0]           opcode_q, opcode_d;
  logic                 mask_on_q, mask_on_d;
  logic [31:0]          key_q, key_d;
  logic [1:0]           idx_q, idx_d;
  logic [LEN_WIDTH-1:0] rem_q, rem_d;
  logic                 closed_q, closed_d;

  logic [6:0]           len7;
  logic                 len_ext;
  logic                 sat;
  logic [LEN_WIDTH-1:0] rem_ext;
  logic [LEN_WIDTH-1:0] rem_dec;
  logic [1:0]           idx_inc;
  logic [7:0]           key_byte;
  logic                 data_op;
  logic                 frame_end;

  assign len7     = rx_byte_i[6:0];
  assign len_ext  = (len7 == wsfd_pkg::LEN7_EXT16) || (len7 == wsfd_pkg::LEN7_EXT64);
  assign sat      = rem_q[LEN_WIDTH-1 -: 8] != 8'd0;
  assign rem_ext  = sat ? '1 : {rem_q[LEN_WIDTH-9:0], rx_byte_i};
  assign rem_dec  = (rem_q != '0) ? rem_q - LEN_WIDTH'(1) : rem_q;
  assign idx_inc  = idx_q + 2'd1;
  assign data_op  = (opcode_q == wsfd_pkg::OP_TEXT) || (opcode_q == wsfd_pkg::OP_BIN);

  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // frame ends on this byte with no payload left, other than on a data frame's last payload byte
  always_comb begin
    frame_end = 1'b0;
    unique case (phase_q)
      wsfd_pkg::PH_HDR2: frame_end = !len_ext && !rx_byte_i[7] && (len7 == 7'd0);
      wsfd_pkg::PH_EXT:  frame_end = (ext_q == 3'd0) && !mask_on_q && (rem_ext == '0);
      wsfd_pkg::PH_MASK: frame_end = (idx_inc == 2'd0) && (rem_q == '0);
      wsfd_pkg::PH_DATA: frame_end = !data_op && (rem_dec == '0);
      default:           frame_end = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_d   = phase_q;
    ext_d     = ext_q;
    opcode_d  = opcode_q;
    mask_on_d = mask_on_q;
    key_d     = key_q;
    idx_d     = idx_q;
    rem_d     = rem_q;
    closed_d  = closed_q;
    if (!closed_q) begin
      unique case (phase_q)
        wsfd_pkg::PH_HDR1: begin
          opcode_d = rx_byte_i[3:0];
          phase_d  = wsfd_pkg::PH_HDR2;
        end
        wsfd_pkg::PH_HDR2: begin
          mask_on_d = rx_byte_i[7];
          key_d     = '0;
          idx_d     = 2'd0;
          rem_d     = '0;
          if (len7 == wsfd_pkg::LEN7_EXT16) begin
            ext_d   = wsfd_pkg::EXT_CNT16;
            phase_d = wsfd_pkg::PH_EXT;
          end else if (len7 == wsfd_pkg::LEN7_EXT64) begin
            ext_d   = wsfd_pkg::EXT_CNT64;
            phase_d = wsfd_pkg::PH_EXT;
          end else begin
            rem_d = LEN_WIDTH'(len7);
            if (rx_byte_i[7]) begin
              phase_d = wsfd_pkg::PH_MASK;
            end else if (len7 == 7'd0) begin
              phase_d = wsfd_pkg::PH_HDR1;
            end else begin
              phase_d = wsfd_pkg::PH_DATA;
            end
          end
        end
        wsfd_pkg::PH_EXT: begin
          rem_d = rem_ext;
          if (ext_q == 3'd0) begin
            if (mask_on_q) begin
              phase_d = wsfd_pkg::PH_MASK;
              idx_d   = 2'd0;
            end else if (rem_ext == '0) begin
              phase_d = wsfd_pkg::PH_HDR1;
            end else begin
              phase_d = wsfd_pkg::PH_DATA;
            end
          end else begin
            ext_d = ext_q - 3'd1;
          end
        end
        wsfd_pkg::PH_MASK: begin
          key_d = {key_q[23:0], rx_byte_i};
          idx_d = idx_inc;
          if (idx_inc == 2'd0) begin
            phase_d = (rem_q == '0) ? wsfd_pkg::PH_HDR1 : wsfd_pkg::PH_DATA;
          end
        end
        wsfd_pkg::PH_DATA: begin
          idx_d = idx_inc;
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = wsfd_pkg::PH_HDR1;
          end
        end
        default: begin
          phase_d = wsfd_pkg::PH_HDR1;
        end
      endcase
      if (frame_end && (opcode_q == wsfd_pkg::OP_CLOSE)) begin
        closed_d = 1'b1;
      end
    end
  end

  // result
  always_comb begin
    res_vld_o       = 1'b0;
    res_o.kind      = wsfd_pkg::KIND_PAYLOAD;
    res_o.data_byte = 8'd0;
    res_o.is_binary = 1'b0;
    res_o.last      = 1'b1;
    if (!closed_q) begin
      if ((phase_q == wsfd_pkg::PH_DATA) && data_op) begin
        res_vld_o       = 1'b1;
        res_o.kind      = wsfd_pkg::KIND_PAYLOAD;
        res_o.data_byte = rx_byte_i ^ key_byte;
        res_o.is_binary = opcode_q == wsfd_pkg::OP_BIN;
        res_o.last      = rem_dec == '0;
      end else if (frame_end) begin
        if (data_op) begin
          res_vld_o       = 1'b1;
          res_o.kind      = wsfd_pkg::KIND_EMPTY;
          res_o.is_binary = opcode_q == wsfd_pkg::OP_BIN;
        end else if (opcode_q == wsfd_pkg::OP_CLOSE) begin
          res_vld_o  = 1'b1;
          res_o.kind = wsfd_pkg::KIND_CLOSE;
        end else if (opcode_q == wsfd_pkg::OP_PING) begin
          res_vld_o  = 1'b1;
          res_o.kind = wsfd_pkg::KIND_PING;
        end else if (opcode_q == wsfd_pkg::OP_PONG) begin
          res_vld_o  = 1'b1;
          res_o.kind = wsfd_pkg::KIND_PONG;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wsfd_pkg::PH_HDR1;
      ext_q     <= 3'd0;
      opcode_q  <= 4'd0;
      mask_on_q <= 1'b0;
      key_q     <= 32'd0;
      idx_q     <= 2'd0;
      rem_q     <= '0;
      closed_q  <= 1'b0;
    end else if (req_i) begin
      phase_q   <= phase_d;
      ext_q     <= ext_d;
      opcode_q  <= opcode_d;
      mask_on_q <= mask_on_d;
      key_q     <= key_d;
      idx_q     <= idx_d;
      rem_q     <= rem_d;
      closed_q  <= closed_d;
    end
  end

endmodule

FILE: design/wsfd_out.sv
// ----------------------------------------------------------------------------
// wsfd_out
// Result register with skid stage; ready toward the parser is registered.
// ----------------------------------------------------------------------------
module wsfd_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_vld_i,
  input  wsfd_pkg::res_t in_res_i,
  output logic           in_rdy_o,
  output logic           out_vld_o,
  output wsfd_pkg::res_t out_res_o,
  input  logic           out_rdy_i
);

  logic           main_vld_q;
  wsfd_pkg::res_t main_q;
  logic           skid_vld_q;
  wsfd_pkg::res_t skid_q;
  logic           push;

  assign in_rdy_o  = !skid_vld_q;
  assign push      = in_vld_i && !skid_vld_q;
  assign out_vld_o = main_vld_q;
  assign out_res_o = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!main_vld_q || out_rdy_i) begin
      main_vld_q <= skid_vld_q || push;
      skid_vld_q <= 1'b0;
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_vld_q || out_rdy_i) begin
      main_q <= skid_vld_q ? skid_q : in_res_i;
    end else if (push) begin
      skid_q <= in_res_i;
    end
  end

endmodule

FILE: design/websocket_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Receive-side WebSocket frame parser: one stream byte in, at most one result.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while s_axis_tready is high; the frame state
// updates in the accepting cycle. Each result is registered before it is on m_axis.
// A stalled output is absorbed by a one-entry skid stage; s_axis_tready is
// registered and drops only while that skid entry is full.
// Reset (rst_ni low, asynchronous) returns the parser to the first header byte
// and clears the closed state and both output entries.
module websocket_frame_deframer_unit #(
  parameter int unsigned LEN_WIDTH = wsfd_pkg::LenWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
  output logic [3:0]  m_axis_tuser,   // [2:0] kind, [3] is_binary
  output logic        m_axis_tlast    // last
);

  logic           req;
  logic           res_vld;
  wsfd_pkg::res_t res;
  wsfd_pkg::res_t out_res;

  assign req = s_axis_tvalid && s_axis_tready;

  wsfd_parse #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rx_byte_i (s_axis_tdata),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  wsfd_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (req && res_vld),
    .in_res_i  (res),
    .in_rdy_o  (s_axis_tready),
    .out_vld_o (m_axis_tvalid),
    .out_res_o (out_res),
    .out_rdy_i (m_axis_tready)
  );

  assign m_axis_tdata = out_res.data_byte;
  assign m_axis_tuser = {out_res.is_binary, out_res.kind};
  assign m_axis_tlast = out_res.last;

endmodule

FILE: design/wsfd_checker.sv
// ----------------------------------------------------------------------------
// wsfd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module wsfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic [2:0] kind;
  assign kind = m_axis_tuser[2:0];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (kind == wsfd_pkg::KIND_PAYLOAD) || (kind == wsfd_pkg::KIND_EMPTY) ||
      (kind == wsfd_pkg::KIND_CLOSE) || (kind == wsfd_pkg::KIND_PING) ||
      (kind == wsfd_pkg::KIND_PONG))
    else $error("bad result kind");

  a_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind != wsfd_pkg::KIND_PAYLOAD) |->
      m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("event without last or with data");

  a_ctl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind != wsfd_pkg::KIND_PAYLOAD) && (kind != wsfd_pkg::KIND_EMPTY) |->
      !m_axis_tuser[3])
    else $error("control event flagged binary");

  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid) && !$past(m_axis_tready))
    else $error("input stalled with room in output");

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the WebSocket frame deframer against its own frame parser. Whole
// frames of every opcode, length form and masking go in as a byte stream.
// Each payload byte or event that comes out is compared with the oldest
// predicted result. Both stream sides stall at random in two of three idling modes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned LenW       = wsfd_pkg::LenWidthDefault;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxShown   = 10;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;

  class deframer_sb;
    wsfd_pkg::phase_e ph;
    logic [2:0]       ext_left;
    logic [3:0]       opcode;
    logic             masked;
    logic [31:0]      key;
    logic [1:0]       key_pos;
    logic [LenW-1:0]  bytes_left;
    logic             closed;
    wsfd_pkg::res_t   expected_q[$];
    int unsigned      mismatches;

    function new();
      ph         = wsfd_pkg::PH_HDR1;
      ext_left   = '0;
      opcode     = '0;
      masked     = 1'b0;
      key        = '0;
      key_pos    = '0;
      bytes_left = '0;
      closed     = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function bit carries_data();
      return opcode == wsfd_pkg::OP_TEXT || opcode == wsfd_pkg::OP_BIN;
    endfunction

    function void push(wsfd_pkg::kind_e k, logic [7:0] d, logic bin, logic lst);
      wsfd_pkg::res_t r;
      r.kind      = k;
      r.data_byte = d;
      r.is_binary = bin;
      r.last      = lst;
      expected_q.push_back(r);
    endfunction

    function void frame_end();
      ph = wsfd_pkg::PH_HDR1;
      if (carries_data()) begin
        push(wsfd_pkg::KIND_EMPTY, 8'h00, opcode == wsfd_pkg::OP_BIN, 1'b1);
      end else if (opcode == wsfd_pkg::OP_CLOSE) begin
        closed = 1'b1;
        push(wsfd_pkg::KIND_CLOSE, 8'h00, 1'b0, 1'b1);
      end else if (opcode == wsfd_pkg::OP_PING) begin
        push(wsfd_pkg::KIND_PING, 8'h00, 1'b0, 1'b1);
      end else if (opcode == wsfd_pkg::OP_PONG) begin
        push(wsfd_pkg::KIND_PONG, 8'h00, 1'b0, 1'b1);
      end
    endfunction

    function void length_done();
      if (masked) begin
        ph      = wsfd_pkg::PH_MASK;
        key_pos = '0;
      end else if (bytes_left == 0) begin
        frame_end();
      end else begin
        ph = wsfd_pkg::PH_DATA;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] k;
      logic       fin;
      if (closed) return;
      case (ph)
        wsfd_pkg::PH_HDR1: begin
          opcode = b[3:0];
          ph     = wsfd_pkg::PH_HDR2;
        end
        wsfd_pkg::PH_HDR2: begin
          masked     = b[7];
          key        = '0;
          key_pos    = '0;
          bytes_left = '0;
          if (b[6:0] == wsfd_pkg::LEN7_EXT16) begin
            ext_left = wsfd_pkg::EXT_CNT16;
            ph       = wsfd_pkg::PH_EXT;
          end else if (b[6:0] == wsfd_pkg::LEN7_EXT64) begin
            ext_left = wsfd_pkg::EXT_CNT64;
            ph       = wsfd_pkg::PH_EXT;
          end else begin
            bytes_left = LenW'(b[6:0]);
            length_done();
          end
        end
        wsfd_pkg::PH_EXT: begin
          // saturate rather than shift bits out of the counter
          if (bytes_left > ({LenW{1'b1}} >> 8)) bytes_left = {LenW{1'b1}};
          else bytes_left = (bytes_left << 8) | LenW'(b);
          if (ext_left == 0) length_done();
          else ext_left = ext_left - 3'd1;
        end
        wsfd_pkg::PH_MASK: begin
          key     = {key[23:0], b};
          key_pos = key_pos + 2'd1;
          if (key_pos == 0) begin
            if (bytes_left == 0) frame_end();
            else ph = wsfd_pkg::PH_DATA;
          end
        end
        wsfd_pkg::PH_DATA: begin
          k       = 8'(key >> (24 - 8 * key_pos));
          key_pos = key_pos + 2'd1;
          if (bytes_left != 0) bytes_left = bytes_left - 1;
          if (carries_data()) begin
            fin = (bytes_left == 0);
            if (fin) ph = wsfd_pkg::PH_HDR1;
            push(wsfd_pkg::KIND_PAYLOAD, b ^ k, opcode == wsfd_pkg::OP_BIN, fin);
          end else if (bytes_left == 0) begin
            frame_end();
          end
        end
        default: ph = wsfd_pkg::PH_HDR1;
      endcase
    endfunction

    function void check_result(wsfd_pkg::res_t got);
      wsfd_pkg::res_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("unexpected result: kind=%0d data=%02h bin=%0b last=%0b",
                   got.kind, got.data_byte, got.is_binary, got.last);
        return;
      end
      exp = expected_q.pop_front();
      if (exp.kind !== got.kind || exp.data_byte !== got.data_byte ||
          exp.is_binary !== got.is_binary || exp.last !== got.last) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display({"mismatch: exp kind=%0d data=%02h bin=%0b last=%0b, ",
                    "got kind=%0d data=%02h bin=%0b last=%0b"},
                   exp.kind, exp.data_byte, exp.is_binary, exp.last,
                   got.kind, got.data_byte, got.is_binary, got.last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  deframer_sb  sb;
  int unsigned src_idle_pct = 27;
  int unsigned snk_idle_pct = 48;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;

  websocket_frame_deframer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin : monitor
    wsfd_pkg::res_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind      = wsfd_pkg::kind_e'(m_axis_tuser[2:0]);
        got.data_byte = m_axis_tdata;
        got.is_binary = m_axis_tuser[3];
        got.last      = m_axis_tlast;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [3:0] op, input logic masked, input int unsigned len,
                            input len_form_e form, input logic [31:0] key);
    send_byte({4'($urandom_range(15)), op});
    case (form)
      LEN_SHORT: send_byte({masked, 7'(len)});
      LEN_EXT16: begin
        send_byte({masked, wsfd_pkg::LEN7_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, wsfd_pkg::LEN7_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(8'(64'(len) >> (8 * i)));
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
  endtask

  // data frames dominate; control frames with payload and unknown opcodes mixed in
  task automatic run_random(input int unsigned target);
    int unsigned counted;
    int unsigned start_cnt;
    int unsigned sel;
    int unsigned len;
    len_form_e   form;
    logic [3:0]  op;
    counted = 0;
    while (counted < target) begin
      start_cnt = bytes_sent;
      sel = $urandom_range(99);
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: form = LEN_SHORT;
        6, 7:             form = LEN_EXT16;
        default:          form = LEN_EXT64;
      endcase
      if (form == LEN_SHORT)
        len = ($urandom_range(3) == 0) ? $urandom_range(125) : $urandom_range(12);
      else
        len = ($urandom_range(3) == 0) ? $urandom_range(300) : $urandom_range(20);
      if (sel < 65) begin
        op = $urandom_range(1) ? wsfd_pkg::OP_BIN : wsfd_pkg::OP_TEXT;
      end else if (sel < 85) begin
        op = $urandom_range(1) ? wsfd_pkg::OP_PING : wsfd_pkg::OP_PONG;
      end else begin
        do op = 4'($urandom_range(15));
        while (op inside {wsfd_pkg::OP_TEXT, wsfd_pkg::OP_BIN, wsfd_pkg::OP_CLOSE,
                          wsfd_pkg::OP_PING, wsfd_pkg::OP_PONG});
      end
      send_frame(op, 1'($urandom_range(1)), len, form, $urandom());
      counted += bytes_sent - start_cnt;
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame(wsfd_pkg::OP_TEXT, 1'b0, 0, LEN_SHORT, '0);
    send_byte({4'h8, wsfd_pkg::OP_TEXT});
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte({4'h8, wsfd_pkg::OP_BIN});
    send_byte(8'h81);
    repeat (4) send_byte(8'hFF);
    send_byte(8'h00);
    send_frame(wsfd_pkg::OP_PING, 1'b0, 0, LEN_SHORT, '0);
    send_frame(wsfd_pkg::OP_PONG, 1'b0, 1, LEN_SHORT, '0);
    send_frame(4'h0, 1'b0, 1, LEN_SHORT, '0);
    send_frame(wsfd_pkg::OP_PING, 1'b0, 1, LEN_EXT16, '0);

    run_random(583);
    src_idle_pct = 48;
    snk_idle_pct = 27;
    run_random(583);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(584);

    // close ends the stream; trailing bytes must be dropped
    send_frame(wsfd_pkg::OP_CLOSE, 1'b1, 2, LEN_SHORT, $urandom());
    send_byte(8'h81);
    send_byte(8'h05);
    repeat (6) send_byte(8'($urandom_range(255)));
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
